[rtl/bounded_deque_engine_unit_assert.svh]
// Assertion macros for the bounded deque engine checker.
// Self-contained; no dependencies on other files.
`ifndef BOUNDED_DEQUE_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define BDE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bde checker: same-cycle rule violated");

// Next-cycle implication, switched off while reset is held.
`define BDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bde checker: next-cycle rule violated");

// Next-cycle implication that also holds across reset.
`define BDE_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bde checker: reset rule violated");

`endif

[rtl/bde_pkg.sv]
// Shared types and codes for the bounded deque engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bde_pkg;

    localparam logic [3:0] ACT_PUSH_FRONT = 4'd0;
    localparam logic [3:0] ACT_PUSH_BACK  = 4'd1;
    localparam logic [3:0] ACT_POP_FRONT  = 4'd2;
    localparam logic [3:0] ACT_POP_BACK   = 4'd3;
    localparam logic [3:0] ACT_CLEAR      = 4'd4;
    localparam logic [3:0] ACT_REMOVE     = 4'd5;
    localparam logic [3:0] ACT_READ_ALL   = 4'd6;
    localparam logic [3:0] ACT_READ_FIRST = 4'd7;
    localparam logic [3:0] ACT_READ_LAST  = 4'd8;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] value;
        logic [6:0]         count;
    } t_bde_in;

    typedef struct packed {
        logic signed [31:0] word;
        logic               word_valid;
        logic               last;
        logic [1:0]         status;
        logic [6:0]         occupancy;
        logic [6:0]         removed;
    } t_bde_out;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic simple;
        logic marker;
        logic rd_start;
        logic rd_fetch;
        logic rd_emit;
        logic rm_start;
        logic rm_fetch;
        logic rm_step;
        logic rm_finish;
    } t_bde_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [3:0] action;
        logic       len_zero;
        logic       rd_last;
        logic       rm_done;
        logic       out_free;
    } t_bde_sts;

endpackage

[rtl/bde_ctrl.sv]
// Sequencing state machine for the bounded deque engine.
// Depends on bde_pkg for the command and status structs and action codes.
`timescale 1ns / 1ps

module bde_ctrl
    import bde_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_bde_sts i_sts,
    output t_bde_cmd o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_RD_FETCH = 3'd2;
    localparam logic [2:0] S_RD_EMIT  = 3'd3;
    localparam logic [2:0] S_RM_FETCH = 3'd4;
    localparam logic [2:0] S_RM_CMP   = 3'd5;
    localparam logic [2:0] S_RM_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.action == ACT_REMOVE) begin
                    o_cmd.rm_start = 1'b1;
                    n_state        = S_RM_FETCH;
                end else if (i_sts.action inside {ACT_READ_ALL, ACT_READ_FIRST,
                                                  ACT_READ_LAST}) begin
                    if (!i_sts.len_zero) begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_RD_FETCH;
                    end else if (i_sts.out_free) begin
                        o_cmd.marker = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else if (i_sts.out_free) begin
                    o_cmd.simple = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD_FETCH: begin
                o_cmd.rd_fetch = 1'b1;
                n_state        = S_RD_EMIT;
            end
            S_RD_EMIT: begin
                // read data stays in its register while the output stalls
                if (i_sts.out_free) begin
                    o_cmd.rd_emit = 1'b1;
                    n_state       = i_sts.rd_last ? S_IDLE : S_RD_FETCH;
                end
            end
            S_RM_FETCH: begin
                if (i_sts.rm_done) begin
                    n_state = S_RM_DONE;
                end else begin
                    o_cmd.rm_fetch = 1'b1;
                    n_state        = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                o_cmd.rm_step = 1'b1;
                n_state       = S_RM_FETCH;
            end
            S_RM_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.rm_finish = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/bde_datapath.sv]
// Entry store, pointers, walk counters and output register of the deque engine.
// Depends on bde_pkg; driven by bde_ctrl through t_bde_cmd.
`timescale 1ns / 1ps

module bde_datapath
    import bde_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_bde_in  i_in_data,
    input  t_bde_cmd i_cmd,
    output t_bde_sts o_sts,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_bde_out o_out_data
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;

    logic [WORD_BITS-1:0] mem [CAPACITY];

    logic [ADDR_W-1:0]    r_front, n_front;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_keep, n_keep;
    logic [CNT_W-1:0]     r_removed, n_removed;
    logic [3:0]           r_action;
    logic signed [31:0]   r_value;
    logic [6:0]           r_n;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_out_valid;
    t_bde_out             r_out, n_out;

    logic                 mem_we, mem_re;
    logic [ADDR_W-1:0]    mem_wa, mem_ra;
    logic [WORD_BITS-1:0] mem_wd;

    logic signed [63:0]          val_ext;
    logic [WORD_BITS-1:0]        v_store;
    logic signed [WORD_BITS-1:0] rd_s;
    logic signed [63:0]          rd_ext;
    logic [CMP_W-1:0]            n_ext, cnt_ext;
    logic [CNT_W-1:0]            rd_len, rd_first;
    logic                        full, empty, out_free, out_load;
    logic [1:0]                  res_status;
    logic [ADDR_W-1:0]           slot_back, slot_prev, slot_next, slot_keep;
    logic [ADDR_W-1:0]           slot_idx, slot_rd;

    // front + offset, wrapped once; offset never exceeds the capacity
    function automatic logic [ADDR_W-1:0] f_slot(input logic [ADDR_W-1:0] front,
                                                 input logic [CNT_W:0] off);
        logic [CNT_W+1:0] sum;
        sum = (CNT_W+2)'(front) + (CNT_W+2)'(off);
        if (sum >= (CNT_W+2)'(CAPACITY)) begin
            sum = sum - (CNT_W+2)'(CAPACITY);
        end
        return ADDR_W'(sum);
    endfunction

    assign val_ext = 64'(r_value);
    assign v_store = val_ext[WORD_BITS-1:0];
    assign rd_s    = r_rdata;
    assign rd_ext  = 64'(rd_s);

    assign full     = (r_count == CNT_W'(CAPACITY));
    assign empty    = (r_count == '0);
    assign out_free = !r_out_valid || i_out_ready;

    assign n_ext    = CMP_W'(r_n);
    assign cnt_ext  = CMP_W'(r_count);
    assign rd_len   = (r_action != ACT_READ_ALL && n_ext < cnt_ext) ?
                      CNT_W'(n_ext) : r_count;
    assign rd_first = (r_action == ACT_READ_LAST) ? (r_count - rd_len) : '0;

    assign slot_back = f_slot(r_front, (CNT_W+1)'(r_count));
    assign slot_prev = f_slot(r_front, (CNT_W+1)'(CAPACITY - 1));
    assign slot_next = f_slot(r_front, (CNT_W+1)'(1));
    assign slot_keep = f_slot(r_front, (CNT_W+1)'(r_keep));
    assign slot_idx  = f_slot(r_front, (CNT_W+1)'(r_idx));
    assign slot_rd   = f_slot(r_front, (CNT_W+1)'(rd_first) + (CNT_W+1)'(r_idx));

    assign o_sts.action   = r_action;
    assign o_sts.len_zero = (rd_len == '0);
    assign o_sts.rd_last  = ((CNT_W+1)'(r_idx) + (CNT_W+1)'(1)) == (CNT_W+1)'(rd_len);
    assign o_sts.rm_done  = (r_idx == r_count);
    assign o_sts.out_free = out_free;

    always_comb begin
        n_front    = r_front;
        n_count    = r_count;
        n_idx      = r_idx;
        n_keep     = r_keep;
        n_removed  = r_removed;
        mem_we     = 1'b0;
        mem_wa     = slot_back;
        mem_wd     = v_store;
        mem_re     = 1'b0;
        mem_ra     = slot_idx;
        res_status = ST_OK;
        out_load   = 1'b0;
        n_out      = r_out;

        if (i_cmd.simple) begin
            case (r_action)
                ACT_PUSH_FRONT: begin
                    if (full) begin
                        res_status = ST_FULL;
                    end else begin
                        n_front = slot_prev;
                        mem_we  = 1'b1;
                        mem_wa  = slot_prev;
                        n_count = r_count + 1'b1;
                    end
                end
                ACT_PUSH_BACK: begin
                    if (full) begin
                        res_status = ST_FULL;
                    end else begin
                        mem_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                end
                ACT_POP_FRONT: begin
                    if (empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        n_front = slot_next;
                        n_count = r_count - 1'b1;
                    end
                end
                ACT_POP_BACK: begin
                    if (empty) begin
                        res_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                end
            endcase
            out_load         = 1'b1;
            n_out.word       = '0;
            n_out.word_valid = 1'b0;
            n_out.last       = 1'b1;
            n_out.status     = res_status;
            n_out.occupancy  = 7'(n_count);
            n_out.removed    = '0;
        end

        if (i_cmd.marker) begin
            out_load         = 1'b1;
            n_out.word       = '0;
            n_out.word_valid = 1'b0;
            n_out.last       = 1'b1;
            n_out.status     = ST_OK;
            n_out.occupancy  = 7'(r_count);
            n_out.removed    = '0;
        end

        if (i_cmd.rd_start) begin
            n_idx = '0;
        end
        if (i_cmd.rd_fetch) begin
            mem_re = 1'b1;
            mem_ra = slot_rd;
        end
        if (i_cmd.rd_emit) begin
            out_load         = 1'b1;
            n_out.word       = rd_ext[31:0];
            n_out.word_valid = 1'b1;
            n_out.last       = o_sts.rd_last;
            n_out.status     = ST_OK;
            n_out.occupancy  = 7'(r_count);
            n_out.removed    = '0;
            n_idx            = r_idx + 1'b1;
        end

        if (i_cmd.rm_start) begin
            n_idx     = '0;
            n_keep    = '0;
            n_removed = '0;
        end
        if (i_cmd.rm_fetch) begin
            mem_re = 1'b1;
            mem_ra = slot_idx;
        end
        // survivors are written back behind the read pointer, so no unread entry is hit
        if (i_cmd.rm_step) begin
            if (r_rdata == v_store) begin
                n_removed = r_removed + 1'b1;
            end else begin
                mem_we = 1'b1;
                mem_wa = slot_keep;
                mem_wd = r_rdata;
                n_keep = r_keep + 1'b1;
            end
            n_idx = r_idx + 1'b1;
        end
        if (i_cmd.rm_finish) begin
            n_count          = r_keep;
            out_load         = 1'b1;
            n_out.word       = '0;
            n_out.word_valid = 1'b0;
            n_out.last       = 1'b1;
            n_out.status     = ST_OK;
            n_out.occupancy  = 7'(r_keep);
            n_out.removed    = 7'(r_removed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_in_data.action;
            r_value  <= i_in_data.value;
            r_n      <= i_in_data.count;
        end
        r_idx     <= n_idx;
        r_keep    <= n_keep;
        r_removed <= n_removed;
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/bounded_deque_engine_unit.sv]
// Channel  | Direction | Handshake                | Payload
// in       | input     | i_in_valid / o_in_ready   | i_in_data  (t_bde_in)
// out      | output    | o_out_valid / i_out_ready | o_out_data (t_bde_out)
//
// Push, pop, clear: capture, then update of store and pointers.
// Reads: capture, then one store read and one output load per word returned.
// Remove: capture, a walk of one store read and one compare step per entry, then the result load.
// Synchronous active-low reset clears the front pointer, occupancy and output valid.
// A stalled output holds the read walk; a new transaction is taken while a result waits.
// Top level of the bounded deque engine; depends on bde_pkg, bde_ctrl, bde_datapath.
`timescale 1ns / 1ps

module bounded_deque_engine_unit
    import bde_pkg::*;
#(
    parameter int CAPACITY  = 64,
    parameter int WORD_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_bde_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_bde_out o_out_data
);

    t_bde_cmd cmd;
    t_bde_sts sts;

    bde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bde_datapath #(
        .CAPACITY  (CAPACITY),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[rtl/bde_checker.sv]
// Port-level checker for the bounded deque engine, bound to the top level.
// Depends on bde_pkg and bounded_deque_engine_unit_assert.svh.
`timescale 1ns / 1ps
`include "bounded_deque_engine_unit_assert.svh"

module bde_checker
    import bde_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_bde_in  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_bde_out o_out_data
);

    `BDE_ASSERT_ALWAYS_NEXT(a_rst_clears_out, i_clk, !i_rst_n, !o_out_valid)
    `BDE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `BDE_ASSERT_SAME(a_fault_alone, i_clk, i_rst_n, o_out_valid && o_out_data.status != ST_OK, !o_out_data.word_valid && o_out_data.last)
    `BDE_ASSERT_SAME(a_status_only_last, i_clk, i_rst_n, o_out_valid && !o_out_data.word_valid, o_out_data.last && (o_out_data.word == '0))
    `BDE_ASSERT_SAME(a_removed_no_word, i_clk, i_rst_n, o_out_valid && o_out_data.removed != '0, !o_out_data.word_valid && o_out_data.status == ST_OK)

endmodule

bind bounded_deque_engine_unit bde_checker u_bde_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
